@@ sv/p16e2_pkg.sv @@
package p16e2_pkg;

    // Argument classes on the raw bit pattern
    localparam logic [15:0] POS_TINY_LIM = 16'd221;
    localparam logic [15:0] POS_OVF_LIM  = 16'd29377;
    localparam logic [15:0] NEG_OVF_LIM  = 16'd36159;
    localparam logic [15:0] NEG_TINY_LIM = 16'd65379;

    // Result codes for the special cases
    localparam logic [15:0] POSIT_ONE    = 16'h4000;
    localparam logic [15:0] POSIT_MAXPOS = 16'h7FFF;
    localparam logic [15:0] POSIT_MINPOS = 16'h0001;
    localparam logic [15:0] POSIT_NAR    = 16'h8000;

    // Horner coefficients of 2^t - 1, t with 20 fraction bits
    localparam logic [8:0]  POLY_C0 = 9'd491;
    localparam logic [31:0] POLY_C1 = 32'h9BA0_0000;
    localparam logic [20:0] POLY_C2 = 21'h13_F840;
    localparam logic [23:0] POLY_C3 = 24'h71_8A80;
    localparam logic [29:0] POLY_C4 = 30'h1EC0_4000;
    localparam logic [30:0] POLY_C5 = 31'h2C5C_8000;

    // Cycles from accepted transaction to result strobe
    localparam int LATENCY = 10;

    typedef struct packed {
        logic        special;
        logic [15:0] spec_val;
        logic        neg;
        logic        e;
        logic [3:0]  k;
    } ctl_t;

endpackage

@@ sv/posit16_exp2_unit.sv @@
// Channel   Signals                 Transfer
// -------   ---------------------   ------------------------------------
// command   start, busy, posit_in   edge with start high and busy low
// result    done, posit_out         edge that ends the cycle done is high
//
// One transaction per cycle; busy stays low. Each result passes through
// decode stages, the six-step multiply chain of the fraction polynomial
// (one multiplier per stage) and rounding. Reset clears the valid bits
// only, so nothing in flight survives it. The receiver cannot stall, so
// the pipeline always advances.
module posit16_exp2_unit
    import p16e2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] posit_in,
    output logic        done,
    output logic [15:0] posit_out
);

    logic [LATENCY-1:0] vld_reg;

    // stage 1
    logic [15:0] x1_reg;

    // stage 2: regime run length and argument class
    logic        b2;
    logic        run_found;
    logic [3:0]  cnt2_next;
    ctl_t        ctl2_next;
    logic [15:0] x2_reg;
    logic [3:0]  cnt2_reg;
    ctl_t        ctl2_reg;

    // stage 3: scale and fixed-point alignment
    logic        b3;
    logic [29:0] xs3;
    logic        ebit3;
    logic [11:0] frac3;
    logic [6:0]  cnt2x3;
    logic [6:0]  sc3;
    logic [6:0]  rsh3;
    logic [12:0] mant3;
    logic [24:0] mp3;
    logic [24:0] nbase3;
    logic [3:0]  p3;
    logic [24:0] fill3;
    logic [24:0] mn3;
    logic [19:0] t3_next;
    ctl_t        ctl3_next;

    logic [19:0] t_reg   [3:8];
    ctl_t        ctl_reg [3:9];

    // polynomial stages
    logic [28:0] u4_next, u4_reg;
    logic [31:0] s5;
    logic [51:0] p5;
    logic [17:0] a5_reg;
    logic [20:0] s6;
    logic [40:0] p6;
    logic [20:0] a6_reg;
    logic [23:0] s7;
    logic [43:0] p7;
    logic [27:0] a7_reg;
    logic [29:0] s8;
    logic [49:0] p8;
    logic [28:0] a8_reg;
    logic [30:0] s9;
    logic [50:0] p9;
    logic [26:0] f9_reg;

    // rounding and packing
    logic [44:0] hi10;
    logic [44:0] v10;
    logic [44:0] rb10;
    logic        rnd10;
    logic [44:0] vr10;
    logic [44:0] sh10;
    logic [15:0] posit_out_next;
    logic [15:0] posit_out_reg;

    assign busy      = 1'b0;
    assign done      = vld_reg[LATENCY-1];
    assign posit_out = posit_out_reg;

    always_comb
    begin
        b2        = x1_reg[14];
        run_found = 1'b0;
        cnt2_next = 4'd14;
        for (int i = 0; i < 14; i++)
        begin
            if (!run_found && (x1_reg[13-i] != b2))
            begin
                cnt2_next = 4'(i);
                run_found = 1'b1;
            end
        end

        ctl2_next = '0;
        if (x1_reg < POS_OVF_LIM)
        begin
            ctl2_next.special  = (x1_reg < POS_TINY_LIM);
            ctl2_next.spec_val = POSIT_ONE;
        end
        else if (x1_reg > NEG_OVF_LIM)
        begin
            ctl2_next.special  = (x1_reg > NEG_TINY_LIM);
            ctl2_next.spec_val = POSIT_ONE;
            ctl2_next.neg      = 1'b1;
        end
        else if (x1_reg < POSIT_NAR)
        begin
            ctl2_next.special  = 1'b1;
            ctl2_next.spec_val = POSIT_MAXPOS;
        end
        else if (x1_reg > POSIT_NAR)
        begin
            ctl2_next.special  = 1'b1;
            ctl2_next.spec_val = POSIT_MINPOS;
        end
        else
        begin
            ctl2_next.special  = 1'b1;
            ctl2_next.spec_val = POSIT_NAR;
        end
    end

    always_comb
    begin
        b3     = x2_reg[14];
        xs3    = {14'b0, x2_reg} << cnt2_reg;
        ebit3  = xs3[12];
        frac3  = xs3[11:0];
        cnt2x3 = {2'b00, cnt2_reg, 1'b0};

        // negative arguments decode as the raw two's complement pattern
        if (ctl2_reg.neg)
            sc3 = (b3 ? (7'd7 - cnt2x3) : (7'd9 + cnt2x3)) - {6'b0, ebit3};
        else
            sc3 = (b3 ? (7'd8 + cnt2x3) : (7'd6 - cnt2x3)) + {6'b0, ebit3};
        rsh3 = 7'd0 - sc3;

        mant3 = {1'b1, frac3};
        mp3   = sc3[6] ? ({12'b0, mant3} >> rsh3[5:0]) : ({12'b0, mant3} << sc3[5:0]);

        nbase3 = {12'hFFF, 1'b0, frac3};
        p3     = (rsh3 <= 7'd13) ? 4'(7'd13 - rsh3) : 4'd0;
        fill3  = ~((25'd1 << p3) - 25'd1);
        mn3    = sc3[6] ? ((nbase3 >> rsh3[5:0]) | fill3) : (nbase3 << sc3[5:0]);

        ctl3_next = ctl2_reg;
        if (ctl2_reg.neg)
        begin
            ctl3_next.k = ~mn3[24:21];
            ctl3_next.e = mn3[20];
            t3_next     = mn3[19:0];
        end
        else
        begin
            ctl3_next.k = mp3[24:21];
            ctl3_next.e = mp3[20];
            t3_next     = mp3[19:0];
        end
    end

    always_comb
    begin
        u4_next = t_reg[3] * POLY_C0;
        s5      = POLY_C1 + {3'b0, u4_reg};
        p5      = t_reg[4] * s5;
        s6      = POLY_C2 + {3'b0, a5_reg};
        p6      = t_reg[5] * s6;
        s7      = POLY_C3 + {3'b0, a6_reg};
        p7      = t_reg[6] * s7;
        s8      = POLY_C4 + {2'b0, a7_reg};
        p8      = t_reg[7] * s8;
        s9      = POLY_C5 + {2'b0, a8_reg};
        p9      = t_reg[8] * s9;
    end

    always_comb
    begin
        if (ctl_reg[9].neg)
            hi10 = 45'd1 << 27;
        else
            hi10 = (45'd1 << (6'd29 + {2'b0, ctl_reg[9].k})) - (45'd1 << 28);
        v10   = {18'b0, f9_reg} | hi10 | ({44'b0, ctl_reg[9].e} << 26);
        rb10  = 45'd1 << (5'd13 + {1'b0, ctl_reg[9].k});
        // round half to even at the result's last kept bit
        rnd10 = (|(v10 & rb10)) && ((|(v10 & (rb10 - 45'd1))) || (|(v10 & (rb10 << 1))));
        vr10  = v10 + (rnd10 ? rb10 : 45'd0);
        sh10  = vr10 >> (5'd14 + {1'b0, ctl_reg[9].k});
        posit_out_next = ctl_reg[9].special ? ctl_reg[9].spec_val : sh10[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-2:0], start & ~busy};
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            x1_reg <= posit_in;
        x2_reg     <= x1_reg;
        cnt2_reg   <= cnt2_next;
        ctl2_reg   <= ctl2_next;
        t_reg[3]   <= t3_next;
        ctl_reg[3] <= ctl3_next;
        for (int i = 4; i <= 8; i++)
            t_reg[i] <= t_reg[i-1];
        for (int i = 4; i <= 9; i++)
            ctl_reg[i] <= ctl_reg[i-1];
        u4_reg        <= u4_next;
        a5_reg        <= p5[51:34];
        a6_reg        <= p6[40:20];
        a7_reg        <= p7[43:16];
        a8_reg        <= p8[49:21];
        f9_reg        <= p9[50:24];
        posit_out_reg <= posit_out_next;
    end

endmodule

@@ sv/p16e2_chk.sv @@
module p16e2_chk
    import p16e2_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [15:0] posit_in,
    input logic        done,
    input logic [15:0] posit_out
);

    // every transaction yields a result strobe
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transaction produced no result");

    // no result without a matching earlier transaction
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without transaction");

    a_nar_map: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(posit_in, LATENCY) == POSIT_NAR)) |-> (posit_out == POSIT_NAR))
        else $error("NaR argument did not give NaR");

    a_real_map: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(posit_in, LATENCY) != POSIT_NAR)) |-> (posit_out != POSIT_NAR))
        else $error("real argument gave NaR");

    a_tiny_map: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(posit_in, LATENCY) < POS_TINY_LIM)) |-> (posit_out == POSIT_ONE))
        else $error("tiny argument did not give one");

endmodule

bind posit16_exp2_unit p16e2_chk u_chk (.*);

@@ dv/tb_posit16_exp2_unit.sv @@
`timescale 1ns / 1ps

class exp2_scoreboard;

    typedef struct {
        logic [15:0] operand;
        logic [15:0] result;
    } exp2_txn_t;

    exp2_txn_t pending_results[$];
    int        fail_count;

    function new();
        fail_count = 0;
    endfunction

    // 2^t - 1 for t in [0,1): 20 fraction bits in, 26 out
    static function bit [63:0] poly_exp2_frac(bit [63:0] t);
        bit [63:0] acc;
        acc = (t * (64'h9BA0_0000 + t * 64'd491)) >> 34;
        acc = (t * (64'h0013_F840 + acc)) >> 20;
        acc = (t * (64'h0071_8A80 + acc)) >> 16;
        acc = (t * (64'h1EC0_4000 + acc)) >> 21;
        return (t * (64'h2C5C_8000 + acc)) >> 24;
    endfunction

    // Round to nearest-even at bit 14+r, then drop the low 14+r bits
    static function logic [15:0] round_posit(bit [63:0] v, int unsigned r);
        bit [63:0] half;
        half = 64'd1 << (13 + r);
        if ((v & half) != 0 && ((v & (half - 1)) != 0 || (v & (half << 1)) != 0))
            v = v + half;
        return 16'(v >> (14 + r));
    endfunction

    static function logic [15:0] exp2_positive(logic [15:0] x);
        bit [63:0] m, ip, ebit, k, v;
        int        sc, i;
        m = 64'(x);
        if (m[14])
        begin
            sc = 8;
            for (i = 0; i < 14 && m[13]; i++)
            begin
                m = m << 1;
                sc += 2;
            end
        end
        else
        begin
            sc = 6;
            for (i = 0; i < 14 && !m[13]; i++)
            begin
                m = m << 1;
                sc -= 2;
            end
        end
        if (m[12])
            sc += 1;
        m = (m & 64'h0FFF) | 64'h1000;
        if (sc < 0)
            m = m >> (-sc);
        else
            m = m << sc;
        ip   = (m >> 20) & 64'h3F;
        ebit = (ip & 64'd1) << 26;
        k    = ip >> 1;
        v    = poly_exp2_frac(m & 64'hF_FFFF)
             | ((64'h2000_0000 << k) - 64'h1000_0000) | ebit;
        return round_posit(v, 32'(k));
    endfunction

    static function logic [15:0] exp2_negative(logic [15:0] x);
        bit [63:0]   m, n, ebit, k, v;
        int          sc, i;
        int unsigned d, p;
        m = 64'(x);
        if (m[14])
        begin
            sc = 7;
            for (i = 0; i < 14 && m[13]; i++)
            begin
                m = m << 1;
                sc -= 2;
            end
        end
        else
        begin
            sc = 9;
            for (i = 0; i < 14 && !m[13]; i++)
            begin
                m = m << 1;
                sc += 2;
            end
        end
        if (m[12])
            sc -= 1;
        m = (m & 64'h0FFF) | 64'h01FF_E000;
        if (sc < 0)
        begin
            d = -sc;
            p = (d <= 13) ? 13 - d : 0;
            // fill the vacated high bits with ones
            m = (m >> (d & 63)) | (64'h0200_0000 - (64'd1 << p));
        end
        else
        begin
            m = (m << (sc & 63)) & 64'h01FF_FFFF;
        end
        // floor of x is -n
        n    = 64'd32 - ((m >> 20) & 64'h1F);
        ebit = (n & 64'd1) << 26;
        k    = (n - 64'd1) >> 1;
        v    = poly_exp2_frac(m & 64'hF_FFFF) | 64'h0800_0000 | ebit;
        return round_posit(v, 32'(k));
    endfunction

    static function logic [15:0] exp2_posit(logic [15:0] x);
        if (x < p16e2_pkg::POS_OVF_LIM)
            return (x < p16e2_pkg::POS_TINY_LIM) ? p16e2_pkg::POSIT_ONE : exp2_positive(x);
        if (x > p16e2_pkg::NEG_OVF_LIM)
            return (x > p16e2_pkg::NEG_TINY_LIM) ? p16e2_pkg::POSIT_ONE : exp2_negative(x);
        if (x < p16e2_pkg::POSIT_NAR)
            return p16e2_pkg::POSIT_MAXPOS;
        if (x > p16e2_pkg::POSIT_NAR)
            return p16e2_pkg::POSIT_MINPOS;
        return p16e2_pkg::POSIT_NAR;
    endfunction

    function void note_operand(logic [15:0] operand);
        exp2_txn_t txn;
        txn.operand = operand;
        txn.result  = exp2_posit(operand);
        pending_results.push_back(txn);
    endfunction

    function void check_result(logic [15:0] actual);
        exp2_txn_t txn;
        if (pending_results.size() == 0)
        begin
            $error("posit_out: unexpected result %h with no transaction pending", actual);
            fail_count++;
            return;
        end
        txn = pending_results.pop_front();
        if (actual !== txn.result)
        begin
            $error("posit_out mismatch for posit_in %h: expected %h, actual %h",
                   txn.operand, txn.result, actual);
            fail_count++;
        end
    endfunction

    function void check_drained();
        exp2_txn_t txn;
        while (pending_results.size() != 0)
        begin
            txn = pending_results.pop_front();
            $error("posit_out missing for posit_in %h: expected %h, actual none",
                   txn.operand, txn.result);
            fail_count++;
        end
    endfunction

endclass

module tb_posit16_exp2_unit;

    import p16e2_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CALM_TAIL    = 150;

    // Class boundaries, one, two, minus one and long regimes of both signs
    localparam logic [15:0] EDGE_ARGS [24] = '{
        16'h0000, 16'h0001, 16'd220, 16'd221, 16'h0800, 16'h3000, 16'h4000,
        16'h5000, 16'h6000, 16'h7000, 16'd29376, 16'd29377, 16'h7FFF,
        16'h8000, 16'h8001, 16'd36159, 16'd36160, 16'h9000, 16'hB000,
        16'hC000, 16'hE000, 16'hF800, 16'd65379, 16'd65380
    };

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        start    = 1'b0;
    logic [15:0] posit_in = 16'h0000;
    logic        busy;
    logic        done;
    logic [15:0] posit_out;

    exp2_scoreboard exp2_sb = new();

    posit16_exp2_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .posit_in  (posit_in),
        .done      (done),
        .posit_out (posit_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                exp2_sb.note_operand(posit_in);
            if (done)
                exp2_sb.check_result(posit_out);
        end
    end

    // Hold start and the operand until the block takes the transaction
    task automatic send_operand(input logic [15:0] operand);
        start    <= 1'b1;
        posit_in <= operand;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_burst(input int cycles);
        start    <= 1'b0;
        posit_in <= 16'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Advance one edge first so the last accepted transaction is already noted
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (exp2_sb.pending_results.size() != 0);
    endtask

    function automatic logic [15:0] random_operand();
        logic [15:0] val;
        case ($urandom_range(0, 9))
            6:       val = $urandom_range(0, 1) ? 16'($urandom_range(200, 240))
                                                : 16'($urandom_range(65360, 65535));
            7:       val = $urandom_range(0, 1) ? 16'($urandom_range(29360, 29400))
                                                : 16'($urandom_range(36140, 36180));
            8:       val = 16'($urandom_range(16'h7FF0, 16'h8010));
            9:
            begin
                // long regimes: shrink the magnitude, then pick a sign
                val = 16'($urandom) >> $urandom_range(1, 14);
                if ($urandom_range(0, 1))
                    val = -val;
            end
            default: val = 16'($urandom);
        endcase
        return val;
    endfunction

    initial
    begin
        int i;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (EDGE_ARGS[j])
            send_operand(EDGE_ARGS[j]);
        wait_drained();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_operand(random_operand());
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            else if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_burst($urandom_range(1, 13));
        end
        start <= 1'b0;

        for (i = 0; i < 200 && exp2_sb.pending_results.size() != 0; i++)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        exp2_sb.check_drained();

        if (exp2_sb.fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
